// ===== hdl/tlptw_pkg.sv =====
`timescale 1ns / 1ps

package tlptw_pkg;

   localparam int LEVEL_W    = 10;
   localparam int FRAME_W    = 20;
   localparam int DIR_SHIFT  = 22;
   localparam int OFFSET_W   = 12;
   localparam int ADDR_W     = 32;

   localparam logic [LEVEL_W-1:0] LEVEL_LAST = 10'h3FF;

   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [1:0]         status_type;
   typedef logic [LEVEL_W-1:0] level_index_type;

   typedef struct packed {
      logic      present;
      frame_type frame;
   } tbl_entry_type;

   localparam int TBL_ENTRY_W = $bits(tbl_entry_type);

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam status_type ST_OK           = 2'd0;
   localparam status_type ST_DIR_ABSENT   = 2'd1;
   localparam status_type ST_TABLE_ABSENT = 2'd2;
   localparam status_type ST_POOL_FULL    = 2'd3;

endpackage

// ===== hdl/tlptw_ram.sv =====
`timescale 1ns / 1ps

module tlptw_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/two_level_page_table_walker.sv =====
// Channel   | Ports                                            | Handshake
// ----------+--------------------------------------------------+-------------------------------
// request   | req_operation, req_virtual_address,              | taken when start && !busy
//           | req_physical_address                             |
// response  | rsp_physical_frame, rsp_status                   | rsp_valid strobe, one cycle
//
// A lookup that reaches its table runs from accept through S_DECIDE, the directory read,
// and S_TBL, the table read, back to S_IDLE with the response strobe; the two reads set its length.
// A directory miss, a refused insert or an insert into an existing table ends in S_DECIDE;
// an insert that allocates a table sweeps its 1024 entries in S_CLR, one a cycle.
// After reset the directory is swept clear, all 1024 entries, with busy high.
// The receiver cannot stall; every response is a single-cycle strobe.
`timescale 1ns / 1ps

module two_level_page_table_walker #(
   parameter int TABLE_FRAMES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_operation,
   input  logic [31:0]            req_virtual_address,
   input  logic [31:0]            req_physical_address,
   output logic                   rsp_valid,
   output tlptw_pkg::frame_type   rsp_physical_frame,
   output tlptw_pkg::status_type  rsp_status
);

   import tlptw_pkg::*;

   // table number width, pool counter width (must hold TABLE_FRAMES itself)
   localparam int TW        = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
   localparam int CW        = $clog2(TABLE_FRAMES + 1);
   localparam int DIR_W     = TW + 1;
   localparam int TAW       = TW + LEVEL_W;
   localparam int TBL_DEPTH = TABLE_FRAMES * (1 << LEVEL_W);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_TBL    = 3'd3;
   localparam logic [2:0] S_CLR    = 3'd4;

   logic [2:0]        state_ff, state_in;
   level_index_type   cnt_ff, cnt_in;
   logic [CW-1:0]     next_free_ff, next_free_in;
   logic [TW-1:0]     tbl_sel_ff, tbl_sel_in;

   logic              op_ff;
   level_index_type   tidx_ff;
   level_index_type   didx_ff;
   frame_type         frame_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   frame_type         rsp_frame_ff, rsp_frame_in;
   status_type        rsp_status_ff, rsp_status_in;

   // memory ports
   logic              dir_we;
   level_index_type   dir_waddr;
   logic [DIR_W-1:0]  dir_wdata;
   level_index_type   dir_raddr;
   logic [DIR_W-1:0]  dir_rdata;
   logic              dir_present;
   logic [TW-1:0]     dir_table;

   logic              tbl_we;
   logic [TAW-1:0]    tbl_waddr;
   tbl_entry_type     tbl_wdata;
   logic [TAW-1:0]    tbl_raddr;
   tbl_entry_type     tbl_rdata;
   logic [TBL_ENTRY_W-1:0] tbl_rdata_raw;

   logic              accept;
   logic              pool_full;

   assign accept      = start && (state_ff == S_IDLE);
   assign busy        = (state_ff != S_IDLE);
   assign pool_full   = (next_free_ff == CW'(TABLE_FRAMES));

   assign dir_present = dir_rdata[TW];
   assign dir_table   = dir_rdata[TW-1:0];
   assign tbl_rdata   = tbl_entry_type'(tbl_rdata_raw);

   // Read the directory straight off the request port so its entry is ready
   // in the cycle after accept; the captured data is only used in S_DECIDE.
   assign dir_raddr = req_virtual_address[DIR_SHIFT +: LEVEL_W];
   // Table read follows the directory entry; consumed in S_TBL.
   assign tbl_raddr = {dir_table, tidx_ff};

   tlptw_ram #(
      .DEPTH (1 << LEVEL_W),
      .AW    (LEVEL_W),
      .DW    (DIR_W)
   ) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .waddr (dir_waddr),
      .wdata (dir_wdata),
      .raddr (dir_raddr),
      .rdata (dir_rdata)
   );

   tlptw_ram #(
      .DEPTH (TBL_DEPTH),
      .AW    (TAW),
      .DW    (TBL_ENTRY_W)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata_raw)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      next_free_in  = next_free_ff;
      tbl_sel_in    = tbl_sel_ff;
      rsp_valid_in  = 1'b0;
      rsp_frame_in  = '0;
      rsp_status_in = ST_OK;

      dir_we        = 1'b0;
      dir_waddr     = didx_ff;
      dir_wdata     = {1'b1, next_free_ff[TW-1:0]};
      tbl_we        = 1'b0;
      tbl_waddr     = {dir_table, tidx_ff};
      tbl_wdata     = '{present: 1'b1, frame: frame_ff};

      case (state_ff)
         S_INIT: begin
            // sweep the directory to not-present, one entry a cycle
            dir_we    = 1'b1;
            dir_waddr = cnt_ff;
            dir_wdata = '0;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LEVEL_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (op_ff == OP_INSERT) begin
               if (dir_present) begin
                  // table exists: write the mapping and respond
                  tbl_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (pool_full) begin
                  // no table left: drop the insert
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_POOL_FULL;
                  state_in      = S_IDLE;
               end else begin
                  // allocate the next table, then sweep it clear
                  dir_we       = 1'b1;
                  tbl_sel_in   = next_free_ff[TW-1:0];
                  next_free_in = next_free_ff + 1'b1;
                  cnt_in       = '0;
                  state_in     = S_CLR;
               end
            end else begin
               if (!dir_present) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_DIR_ABSENT;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_TBL;
               end
            end
         end
         S_TBL: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (tbl_rdata.present) begin
               rsp_frame_in = tbl_rdata.frame;
            end else begin
               rsp_status_in = ST_TABLE_ABSENT;
            end
         end
         S_CLR: begin
            // clear the fresh table; the requested slot gets the mapping instead
            tbl_we    = 1'b1;
            tbl_waddr = {tbl_sel_ff, cnt_ff};
            if (cnt_ff != tidx_ff) begin
               tbl_wdata = '0;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LEVEL_LAST) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request fields for the walk
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         didx_ff  <= req_virtual_address[DIR_SHIFT +: LEVEL_W];
         tidx_ff  <= req_virtual_address[OFFSET_W +: LEVEL_W];
         frame_ff <= req_physical_address[OFFSET_W +: FRAME_W];
      end
   end

   always_ff @(posedge clock) begin
      tbl_sel_ff    <= tbl_sel_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_physical_frame = rsp_frame_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ===== hdl/tlptw_check.sv =====
`timescale 1ns / 1ps

module tlptw_check (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input tlptw_pkg::frame_type  rsp_physical_frame,
   input tlptw_pkg::status_type rsp_status
);

   import tlptw_pkg::*;

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy next cycle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobes");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("response strobe not at end of a walk");

   a_fault_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_physical_frame == '0))
      else $error("fault response carries a nonzero frame");

endmodule

bind two_level_page_table_walker tlptw_check u_tlptw_check (.*);
